// ===== hdl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int SYMBOL_COUNT_DEF  = 256;
	localparam int MAX_CODE_BITS_DEF = 64;

	localparam int SYM_W       = 8;
	localparam int WORD_W      = 64;
	localparam int LEN_IN_W    = 7;
	localparam int SYM_LSB     = 0;
	localparam int WORD_LSB    = SYM_LSB + SYM_W;
	localparam int LEN_LSB     = WORD_LSB + WORD_W;
	localparam int IN_DATA_W   = ((LEN_LSB + LEN_IN_W + 7) / 8) * 8;
	localparam int FUNC_W      = 2;
	localparam int OUT_DATA_W  = 8;
	localparam int PAD_W       = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

	typedef struct packed {
		logic load;
		logic read;
		logic align;
		logic merge;
		logic emit_enc;
		logic finish;
		logic emit_flush;
	} cmd_t;

	typedef struct packed {
		logic sym_ok;
		logic pend_nz;
		logic has_byte;
		logic out_ready;
	} stat_t;

endpackage

// ===== hdl/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/hcbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Sequencer: load, table read, align, merge, byte emission and flush.
// ----------------------------------------------------------------------------
module hcbp_ctrl
	import hcbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic [FUNC_W-1:0] func,
	output logic              s_axis_tready,
	input  stat_t             stat,
	output cmd_t              cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALIGN = 5'b00010,
		S_MERGE = 5'b00100,
		S_EMIT  = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (func_t'(func))
						FUNC_LOAD: begin
							cmd.load = stat.sym_ok;
						end
						FUNC_ENCODE: begin
							if (stat.sym_ok) begin
								cmd.read = 1'b1;
								state_d  = S_ALIGN;
							end
						end
						FUNC_FLUSH: begin
							if (stat.pend_nz) begin
								state_d = S_FLUSH;
							end
						end
						default: ;
					endcase
				end
			end
			S_ALIGN: begin
				cmd.align = 1'b1;
				state_d   = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (stat.has_byte) begin
					cmd.emit_enc = stat.out_ready;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (stat.out_ready) begin
					cmd.emit_flush = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && !stat.has_byte |=> state_q == S_IDLE)
		else $error("encode did not return to idle after last byte");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE)
		else $error("input ready outside idle");
`endif

endmodule

// ===== hdl/hcbp_dp.sv =====
// ----------------------------------------------------------------------------
// hcbp_dp
// Datapath: code table, code alignment, bit buffer, partial byte and the
// output register.
// ----------------------------------------------------------------------------
module hcbp_dp
	import hcbp_pkg::*;
#(
	parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [PAD_W-1:0]      m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam int AW = $clog2(SYMBOL_COUNT);
	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int BW = MAX_CODE_BITS + 8;
	localparam int CW = $clog2(MAX_CODE_BITS + 17);
	localparam int RW = MAX_CODE_BITS + LW;

	logic [SYM_W-1:0]         sym;
	logic [WORD_W-1:0]        word;
	logic [LEN_IN_W-1:0]      len;
	logic [LW-1:0]            len_sat;
	logic [RW-1:0]            rdata;
	logic [MAX_CODE_BITS-1:0] rd_word;
	logic [LW-1:0]            rd_len;
	logic [LW-1:0]            shamt;
	logic                     out_ready;

	logic [MAX_CODE_BITS-1:0] aligned_q;
	logic [LW-1:0]            nbits_q;
	logic [BW-1:0]            buf_q;
	logic [CW-1:0]            cnt_q;
	logic [7:0]               partial_q;
	logic [2:0]               pend_q;
	logic                     m_valid_q;
	logic [OUT_DATA_W-1:0]    m_data_q;
	logic [PAD_W-1:0]         m_pad_q;
	logic                     m_last_q;

	assign sym  = in_data[SYM_LSB +: SYM_W];
	assign word = in_data[WORD_LSB +: WORD_W];
	assign len  = in_data[LEN_LSB +: LEN_IN_W];

	assign len_sat = (len > LEN_IN_W'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS) : len[LW-1:0];

	hcbp_ram #(
		.WIDTH (RW),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (sym[AW-1:0]),
		.wdata ({len_sat, word[MAX_CODE_BITS-1:0]}),
		.re    (cmd.read),
		.raddr (sym[AW-1:0]),
		.rdata (rdata)
	);

	assign rd_word = rdata[MAX_CODE_BITS-1:0];
	assign rd_len  = rdata[MAX_CODE_BITS +: LW];
	assign shamt   = LW'(MAX_CODE_BITS) - rd_len;

	assign out_ready = !m_valid_q || m_axis_tready;

	assign stat.sym_ok    = {1'b0, sym} < (SYM_W + 1)'(SYMBOL_COUNT);
	assign stat.pend_nz   = (pend_q != 3'd0);
	assign stat.has_byte  = (cnt_q >= CW'(8));
	assign stat.out_ready = out_ready;

	always_ff @(posedge clk) begin
		if (cmd.align) begin
			aligned_q <= rd_word << shamt;
			nbits_q   <= rd_len;
		end
		if (cmd.merge) begin
			buf_q <= {partial_q, {MAX_CODE_BITS{1'b0}}} | ({aligned_q, 8'h00} >> pend_q);
		end else if (cmd.emit_enc) begin
			buf_q <= buf_q << 8;
		end
		if (cmd.emit_enc) begin
			m_data_q <= buf_q[BW-1 -: 8];
			m_pad_q  <= '0;
			m_last_q <= (cnt_q < CW'(16));
		end else if (cmd.emit_flush) begin
			m_data_q <= partial_q;
			m_pad_q  <= PAD_W'(4'd8 - {1'b0, pend_q});
			m_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			partial_q <= '0;
			pend_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.merge) begin
				cnt_q <= CW'(pend_q) + CW'(nbits_q);
			end else if (cmd.emit_enc) begin
				cnt_q <= cnt_q - CW'(8);
			end
			if (cmd.finish) begin
				partial_q <= buf_q[BW-1 -: 8];
				pend_q    <= cnt_q[2:0];
			end else if (cmd.emit_flush) begin
				partial_q <= '0;
				pend_q    <= '0;
			end
			if (cmd.emit_enc || cmd.emit_flush) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_pad_q;
	assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
	a_partial_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q & (8'hFF >> pend_q)) == 8'h00)
		else $error("partial byte has bits below the pending count");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_enc || cmd.emit_flush) |-> out_ready)
		else $error("byte emitted into a full output register");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |=> cnt_q <= CW'(MAX_CODE_BITS + 7))
		else $error("bit count exceeds buffer");
`endif

endmodule

// ===== hdl/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Load writes one table entry; flush emits the partial byte (nothing with no
// bits pending); encode runs table read, align shift, merge, then B output
// bytes (0..8), one byte per cycle while the receiver is ready, through the
// single output register, then stores the partial byte. A stalled receiver
// holds flush and encode. One transaction is worked at a time; table RAM has
// no reset, the partial byte, bit count, FSM and output valid clear on arst_n.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
	import hcbp_pkg::*;
#(
	parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // symbol, code_word, code_length, zero fill
	input  logic [FUNC_W-1:0]     s_axis_tuser,  // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_byte
	output logic [PAD_W-1:0]      m_axis_tuser,  // pad_bits
	output logic                  m_axis_tlast
);

	cmd_t  cmd;
	stat_t stat;

	hcbp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.func          (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	hcbp_dp #(
		.SYMBOL_COUNT  (SYMBOL_COUNT),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (s_axis_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
